[rtl/linear_probe_hash_table_defines.svh]
// assertion macros for the linear probing hash table
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht assertion failed");

// next-cycle implication, checked out of reset
`define LPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht assertion failed");

`endif

[rtl/lpht_pkg.sv]
// shared constants, types and helpers of the linear probing hash table
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // table geometry
    localparam int TABLE_SLOTS = 16;
    localparam int KEY_BYTES   = 8;

    // fixed field widths
    localparam int FUNC_W     = 1;
    localparam int KEY_W      = 64;
    localparam int LEN_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;

    // derived widths
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int SUM_W  = $clog2(KEY_BYTES * 255 + 1);

    typedef logic [FUNC_W-1:0]     t_func;
    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [SLOT_OUT_W-1:0] t_slot_out;

    // operation codes
    localparam t_func FUNC_INSERT = 1'b0;
    localparam t_func FUNC_SEARCH = 1'b1;

    // status codes
    localparam t_status STAT_INSERTED  = 3'd0;
    localparam t_status STAT_PRESENT   = 3'd1;
    localparam t_status STAT_FULL      = 3'd2;
    localparam t_status STAT_FOUND     = 3'd3;
    localparam t_status STAT_NOT_FOUND = 3'd4;

    // clamp a key length to the supported byte count
    function automatic t_len len_sat(input t_len len);
        t_len res;
        if (len > LEN_W'(KEY_BYTES)) begin
            res = LEN_W'(KEY_BYTES);
        end else begin
            res = len;
        end
        return res;
    endfunction

    // keep only the bytes below the (saturated) length
    function automatic t_key key_mask(input t_len len);
        t_key res;
        res = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if ((b < KEY_BYTES) && (LEN_W'(b) < len)) begin
                res[8*b +: 8] = 8'hff;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/lpht_req_if.sv]
// request channel of the linear probing hash table
`timescale 1ns / 1ps
`default_nettype none

interface lpht_req_if;
    logic               valid;
    logic               ready;
    lpht_pkg::t_func    func;
    lpht_pkg::t_key     key;
    lpht_pkg::t_len     key_len;

    modport source (output valid, output func, output key, output key_len, input ready);
    modport sink   (input valid, input func, input key, input key_len, output ready);
endinterface

`default_nettype wire

[rtl/lpht_rsp_if.sv]
// response channel of the linear probing hash table
`timescale 1ns / 1ps
`default_nettype none

interface lpht_rsp_if;
    logic                  valid;
    logic                  ready;
    lpht_pkg::t_status     status;
    lpht_pkg::t_slot_out   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

[rtl/linear_probe_hash_table.sv]
// Sequence: accept, hash the key bytes, reduce the sum modulo the slot count when that
//   count is not a power of two, probe slot by slot (an occupied slot adds a compare step,
//   and a full sweep adds a final check), then register the result.
// Throughput: one request at a time, set by the single probe loop and its one-port key
//   memory; the next request is taken in the cycle after the result is registered.
// Reset clears the valid bit of every slot at once, so the table is empty; no clear pass.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lpht_req_if.sink     i_req,
    lpht_rsp_if.source   o_rsp
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam int  SLOT_W     = lpht_pkg::SLOT_W;
    localparam int  CNT_W      = lpht_pkg::CNT_W;
    localparam int  SUM_W      = lpht_pkg::SUM_W;
    localparam int  KEY_W      = lpht_pkg::KEY_W;
    localparam int  LEN_W      = lpht_pkg::LEN_W;
    localparam int  BYTE_CNT_W = (lpht_pkg::KEY_BYTES > 1) ? $clog2(lpht_pkg::KEY_BYTES) : 1;
    localparam int  MSH_W      = $clog2(SUM_W);
    localparam int  MOD_W      = SUM_W + SLOT_W + 1;
    localparam bit  SLOTS_POW2 =
        ((lpht_pkg::TABLE_SLOTS & (lpht_pkg::TABLE_SLOTS - 1)) == 0);
    localparam int SLOT_OUT_PAD = lpht_pkg::SLOT_OUT_W;

    // control state
    logic [2:0]                         r_state, n_state;
    logic [lpht_pkg::TABLE_SLOTS-1:0]   r_used, n_used;
    logic                               r_rsp_valid, n_rsp_valid;

    // request payload and working registers
    lpht_pkg::t_func        r_func, n_func;
    lpht_pkg::t_key         r_key, n_key;
    lpht_pkg::t_len         r_len, n_len;
    lpht_pkg::t_key         r_hash_key, n_hash_key;
    logic [BYTE_CNT_W-1:0]  r_byte, n_byte;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [MSH_W-1:0]       r_mod_sh, n_mod_sh;
    logic [SLOT_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]       r_probe_cnt, n_probe_cnt;
    lpht_pkg::t_status      r_res_status, n_res_status;
    logic [SLOT_W-1:0]      r_res_slot, n_res_slot;
    lpht_pkg::t_status      r_out_status, n_out_status;
    lpht_pkg::t_slot_out    r_out_slot, n_out_slot;

    // key and length memories, one shared address, registered read
    logic [KEY_W-1:0]       r_key_mem [lpht_pkg::TABLE_SLOTS];
    logic [LEN_W-1:0]       r_len_mem [lpht_pkg::TABLE_SLOTS];
    logic [KEY_W-1:0]       r_rd_key;
    logic [LEN_W-1:0]       r_rd_len;
    logic                   w_we;

    // shared datapath
    lpht_pkg::t_len         w_len_sat;
    logic [SUM_W-1:0]       w_add;
    logic [MOD_W-1:0]       w_div;
    logic [MOD_W-1:0]       w_sum_wide;
    logic [MOD_W-1:0]       w_sub;
    logic [SUM_W-1:0]       w_mod_next;
    logic [SUM_W+SLOT_W-1:0] w_add_ext;
    logic [SUM_W+SLOT_W-1:0] w_mod_ext;
    logic [SLOT_W+SLOT_OUT_PAD-1:0] w_slot_ext;
    logic [SLOT_W-1:0]      w_idx_next;
    logic                   w_hit;
    logic                   w_is_insert;
    logic                   w_accept;
    logic                   w_out_take;

    // only an idle sequencer takes a request
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_rsp.valid  = r_rsp_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;

    // output register can be loaded when empty or being drained
    assign w_out_take = !r_rsp_valid || o_rsp.ready;

    assign w_len_sat   = lpht_pkg::len_sat(i_req.key_len);
    assign w_is_insert = (r_func == lpht_pkg::FUNC_INSERT);

    // accumulator: one key byte per hash cycle
    assign w_add     = r_sum + SUM_W'(r_hash_key[7:0]);
    assign w_add_ext = {{SLOT_W{1'b0}}, w_add};

    // restoring reduction: one shifted compare-subtract per cycle
    assign w_div      = MOD_W'(lpht_pkg::TABLE_SLOTS) << r_mod_sh;
    assign w_sum_wide = MOD_W'(r_sum);
    assign w_sub      = w_sum_wide - w_div;
    assign w_mod_next = (w_sum_wide >= w_div) ? w_sub[SUM_W-1:0] : r_sum;
    assign w_mod_ext  = {{SLOT_W{1'b0}}, w_mod_next};

    // forward probe step with wrap
    assign w_idx_next = (r_idx == SLOT_W'(lpht_pkg::TABLE_SLOTS - 1)) ?
                        '0 : r_idx + SLOT_W'(1);

    // stored entry matches on length and masked bytes
    assign w_hit = (r_rd_len == r_len) && (r_rd_key == r_key);

    // slot index as reported, masked to the output width
    assign w_slot_ext = {{SLOT_OUT_PAD{1'b0}}, r_res_slot};

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;
        n_func       = r_func;
        n_key        = r_key;
        n_len        = r_len;
        n_hash_key   = r_hash_key;
        n_byte       = r_byte;
        n_sum        = r_sum;
        n_mod_sh     = r_mod_sh;
        n_idx        = r_idx;
        n_probe_cnt  = r_probe_cnt;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        w_we         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_func      = i_req.func;
                    n_len       = w_len_sat;
                    n_key       = i_req.key & lpht_pkg::key_mask(w_len_sat);
                    n_hash_key  = i_req.key & lpht_pkg::key_mask(w_len_sat);
                    n_sum       = '0;
                    n_byte      = '0;
                    n_probe_cnt = '0;
                    n_state     = S_HASH;
                end
            end
            S_HASH: begin
                n_sum      = w_add;
                n_hash_key = r_hash_key >> 8;
                n_byte     = r_byte + BYTE_CNT_W'(1);
                if (r_byte == BYTE_CNT_W'(lpht_pkg::KEY_BYTES - 1)) begin
                    // power-of-two table: home slot is the low sum bits
                    n_idx    = w_add_ext[SLOT_W-1:0];
                    n_mod_sh = MSH_W'(SUM_W - 1);
                    n_state  = SLOTS_POW2 ? S_PROBE : S_MOD;
                end
            end
            S_MOD: begin
                n_sum    = w_mod_next;
                n_mod_sh = r_mod_sh - MSH_W'(1);
                if (r_mod_sh == '0) begin
                    n_idx   = w_mod_ext[SLOT_W-1:0];
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                priority if (r_probe_cnt == CNT_W'(lpht_pkg::TABLE_SLOTS)) begin
                    // every slot visited without a hole or a match
                    n_res_status = w_is_insert ? lpht_pkg::STAT_FULL : lpht_pkg::STAT_NOT_FOUND;
                    n_res_slot   = '0;
                    n_state      = S_OUT;
                end else if (!r_used[r_idx]) begin
                    if (w_is_insert) begin
                        w_we           = 1'b1;
                        n_used[r_idx]  = 1'b1;
                        n_res_status   = lpht_pkg::STAT_INSERTED;
                        n_res_slot     = r_idx;
                    end else begin
                        n_res_status   = lpht_pkg::STAT_NOT_FOUND;
                        n_res_slot     = '0;
                    end
                    n_state = S_OUT;
                end else begin
                    // occupied: stored entry arrives next cycle
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_hit) begin
                    n_res_status = w_is_insert ? lpht_pkg::STAT_PRESENT : lpht_pkg::STAT_FOUND;
                    n_res_slot   = r_idx;
                    n_state      = S_OUT;
                end else begin
                    n_idx       = w_idx_next;
                    n_probe_cnt = r_probe_cnt + CNT_W'(1);
                    n_state     = S_PROBE;
                end
            end
            S_OUT: begin
                if (w_out_take) begin
                    n_out_status = r_res_status;
                    n_out_slot   = w_slot_ext[lpht_pkg::SLOT_OUT_W-1:0];
                    n_rsp_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_key        <= n_key;
        r_len        <= n_len;
        r_hash_key   <= n_hash_key;
        r_byte       <= n_byte;
        r_sum        <= n_sum;
        r_mod_sh     <= n_mod_sh;
        r_idx        <= n_idx;
        r_probe_cnt  <= n_probe_cnt;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    // key and length store, written on insert into an empty slot
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_key_mem[r_idx] <= r_key;
            r_len_mem[r_idx] <= r_len;
        end
        r_rd_key <= r_key_mem[r_idx];
        r_rd_len <= r_len_mem[r_idx];
    end

    // slots once filled stay filled
    `LPHT_ASSERT_NXT(a_used_sticky, i_clk, i_rst_n, 1'b1, (r_used & $past(r_used)) == $past(r_used))
    // an insert result points at an occupied slot
    `LPHT_ASSERT_IMP(a_insert_used, i_clk, i_rst_n, (r_state == S_OUT) && (r_res_status == lpht_pkg::STAT_INSERTED), r_used[r_res_slot])
    // a compare never runs past the last slot
    `LPHT_ASSERT_IMP(a_cmp_bound, i_clk, i_rst_n, r_state == S_CMP, r_probe_cnt < CNT_W'(lpht_pkg::TABLE_SLOTS))
    // a new response only comes out of the result state
    `LPHT_ASSERT_IMP(a_rsp_source, i_clk, i_rst_n, $rose(r_rsp_valid), $past(r_state) == S_OUT)

endmodule

`default_nettype wire

[test/linear_probe_hash_table_checker.sv]
// request/response scoreboard for the linear probing hash table
`timescale 1ns / 1ps

module linear_probe_hash_table_checker (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpht_req_if         i_req,
    lpht_rsp_if         i_rsp,
    output logic [31:0] o_fail_count,
    output logic [31:0] o_pending
);
    import lpht_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_status   status;
        t_slot_out slot;
    } lookup_outcome_t;

    // shadow copy of the table contents
    t_key stored_key [TABLE_SLOTS];
    t_len stored_len [TABLE_SLOTS];
    logic slot_taken [TABLE_SLOTS];

    lookup_outcome_t outcome_q[$];

    // walk the shadow table for one request, updating it on a successful insert
    function automatic lookup_outcome_t hash_lookup(input t_func op, input t_key raw_key,
                                                    input t_len raw_len);
        t_len            len;
        t_key            key;
        int unsigned     byte_sum;
        int unsigned     idx;
        lookup_outcome_t res;
        len      = (raw_len > t_len'(KEY_BYTES)) ? t_len'(KEY_BYTES) : raw_len;
        key      = '0;
        byte_sum = 0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (b < len) begin
                key[8*b +: 8] = raw_key[8*b +: 8];
                byte_sum += raw_key[8*b +: 8];
            end
        end
        res.status = (op == FUNC_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
        res.slot   = '0;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            idx = (byte_sum + n) % TABLE_SLOTS;
            if (!slot_taken[idx]) begin
                if (op == FUNC_INSERT) begin
                    stored_key[idx] = key;
                    stored_len[idx] = len;
                    slot_taken[idx] = 1'b1;
                    res.status      = STAT_INSERTED;
                    res.slot        = t_slot_out'(idx);
                end
                break;
            end
            if (stored_len[idx] == len && stored_key[idx] == key) begin
                res.status = (op == FUNC_INSERT) ? STAT_PRESENT : STAT_FOUND;
                res.slot   = t_slot_out'(idx);
                break;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        lookup_outcome_t got;
        lookup_outcome_t want;
        int unsigned     new_fails;
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                slot_taken[s] = 1'b0;
            end
            outcome_q.delete();
            o_fail_count <= '0;
            o_pending    <= '0;
        end else begin
            new_fails = 0;
            if (i_req.valid && i_req.ready) begin
                outcome_q.push_back(hash_lookup(i_req.func, i_req.key, i_req.key_len));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.status = i_rsp.status;
                got.slot   = i_rsp.slot;
                if (outcome_q.size() == 0) begin
                    new_fails++;
                    if (o_fail_count + new_fails <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected response: status %0d slot %0d",
                                 $realtime, got.status, got.slot);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status != want.status || got.slot != want.slot) begin
                        new_fails++;
                        if (o_fail_count + new_fails <= REPORT_LIMIT) begin
                            $display("[%0t] mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                                     $realtime, want.status, want.slot, got.status, got.slot);
                        end
                    end
                end
            end
            o_fail_count <= o_fail_count + new_fails;
            o_pending    <= outcome_q.size();
        end
    end

endmodule

[test/linear_probe_hash_table_tb.sv]
// stimulus and verdict for the linear probing hash table
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
    import lpht_pkg::*;

    localparam int RANDOM_REQUESTS = 830;
    localparam int POOL_SIZE       = 28;
    localparam int DRAIN_EVERY     = 200;
    localparam int SETTLE_CYCLES   = 60;      // above the worst probe latency
    localparam int CYCLE_LIMIT     = 400000;

    // response-side stall patterns
    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_mode_t;

    typedef struct {
        t_key key;
        t_len len;
    } pool_entry_t;

    logic        i_clk;
    logic        i_rst_n;
    logic [31:0] fail_count;
    logic [31:0] pending_count;
    int unsigned cycle_count = 0;

    // sender pacing: requests go out in bursts separated by idle gaps
    int unsigned burst_left = 0;

    // receiver stall pattern state
    rx_mode_t    rx_mode      = RX_ALWAYS;
    int unsigned rx_mode_left = 0;
    logic [7:0]  rx_tick      = '0;

    pool_entry_t key_pool [POOL_SIZE];

    lpht_req_if req_ch ();
    lpht_rsp_if rsp_ch ();

    linear_probe_hash_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    linear_probe_hash_table_checker u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response ready: switch between stall patterns at random
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_t'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(20, 120);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: begin
                rsp_ch.ready <= 1'b1;
            end
            RX_RANDOM: begin
                rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
                rsp_ch.ready <= (rx_tick[2:0] == 3'd0);   // ready when the low three tick bits are zero
            end
            default: begin
                rsp_ch.ready <= ((rx_tick % 5) < 2);
            end
        endcase
    end

    // present one request and hold it until the block takes it
    task automatic send_request(input t_func op, input t_key key, input t_len len);
        req_ch.valid   <= 1'b1;
        req_ch.func    <= op;
        req_ch.key     <= key;
        req_ch.key_len <= len;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // send a request, then maybe close the burst with an idle gap
    task automatic issue(input t_func op, input t_key key, input t_len len);
        int unsigned gap;
        send_request(op, key, len);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // about a third of the bursts run straight into the next one
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(0, 15);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop sending until every outstanding request has been answered
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    initial begin : stimulus
        t_func       op;
        t_key        key;
        t_key        garbage;
        t_key        mask;
        t_len        len;
        pool_entry_t entry;

        req_ch.valid   <= 1'b0;
        req_ch.func    <= FUNC_INSERT;
        req_ch.key     <= '0;
        req_ch.key_len <= '0;
        i_rst_n        <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty key, with junk above its zero length, lands in slot 0
        issue(FUNC_INSERT, 64'hDEAD_BEEF_0123_4567, 4'd0);
        issue(FUNC_SEARCH, 64'h0, 4'd0);
        // all-ones key of full length, then found again through a saturated length
        issue(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        issue(FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        // junk above the length is ignored
        issue(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FF01, 4'd1);
        // collides with slot 0 and slot 1, probes on to slot 2
        issue(FUNC_INSERT, 64'h0000_0000_0000_0010, 4'd1);
        issue(FUNC_SEARCH, 64'hABCD_EF98_7654_3210, 4'd1);
        // same bytes, different length: a distinct key
        issue(FUNC_INSERT, 64'h0000_0000_0000_0001, 4'd2);
        issue(FUNC_INSERT, 64'h5A5A_5A5A_5A5A_5A01, 4'd1);
        issue(FUNC_SEARCH, 64'h0000_0000_0000_0001, 4'd2);
        // probe chain ends at an empty slot
        issue(FUNC_SEARCH, 64'h0000_0000_0000_0001, 4'd3);
        // top bit of the last byte
        issue(FUNC_INSERT, 64'h8000_0000_0000_0000, 4'd8);
        issue(FUNC_SEARCH, 64'h8000_0000_0000_0000, 4'd7);
        // last slot, then a key that wraps round to the front
        issue(FUNC_INSERT, 64'h0000_0000_0000_000F, 4'd1);
        issue(FUNC_INSERT, 64'h0000_0000_0000_001F, 4'd1);
        issue(FUNC_SEARCH, 64'h0000_0000_0000_001F, 4'd1);
        issue(FUNC_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF, 4'd12);
        wait_for_drain();

        // random: mostly keys from a small pool so inserts, hits and misses all recur;
        // the pool outgrows the table, so it fills and later inserts report full
        for (int p = 0; p < POOL_SIZE; p++) begin
            key_pool[p].key = {$urandom, $urandom};
            key_pool[p].len = t_len'($urandom_range(0, 8));
        end
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            op      = ($urandom_range(0, 1) == 0) ? FUNC_INSERT : FUNC_SEARCH;
            garbage = {$urandom, $urandom};
            if ($urandom_range(0, 99) < 80) begin
                entry = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                len   = entry.len;
                if (len == t_len'(KEY_BYTES) && $urandom_range(0, 3) == 0) begin
                    len = t_len'($urandom_range(9, 15));
                end
                mask = '0;
                for (int b = 0; b < KEY_BYTES; b++) begin
                    if (b < entry.len) begin
                        mask[8*b +: 8] = 8'hFF;
                    end
                end
                key = (entry.key & mask) | (garbage & ~mask);
            end else begin
                key = garbage;
                len = t_len'($urandom_range(0, 15));
            end
            issue(op, key, len);
            if ((i % DRAIN_EVERY) == DRAIN_EVERY - 1) begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
